[hw/rtl/sll_pkg.sv]
// ----------------------------------------------------------------------------
// sll_pkg
// Shared constants, types and helpers of the static linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int unsigned SLOTS     = 128;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned HEAD_SLOT = SLOTS - 1;
  localparam int unsigned FREE_HEAD = 0;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_HEAD,
    S_A_NEXT,
    S_A_CLR,
    S_A_LINK,
    S_D_WALK,
    S_D_VNEXT,
    S_D_FREE,
    S_D_PUSH
  } state_e;

  // link value of a slot right after reset: free slots chained, list empty
  function automatic slot_t link_reset_value(input slot_t idx);
    slot_t res;
    if (idx < slot_t'(SLOTS - 2)) begin
      res = idx + slot_t'(1);
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

[hw/rtl/static_linked_list_engine_top.sv]
// ----------------------------------------------------------------------------
// static_linked_list_engine_top
// Array-backed singly linked list with a free list, held in a link RAM.
//
// Input channel (in_valid_i/in_ready_o) carries an operation: append value_i
// at the tail, or delete the element at 1-based position_i. Each transfer
// gives exactly one result on the output channel (out_valid_o/out_ready_i):
// status, slot taken or freed, and the list length afterwards.
// An append ends early if the store is full, and a zero or too large position
// is answered from idle. Every link visited costs one read of the link RAM,
// which has registered read data, so the walk sets the delete time.
// One operation is in flight at a time; a new one is taken when the previous
// result has left or leaves in the same cycle.
// After reset the link RAM is initialized in a pass over all 128 slots, one slot
// a cycle, with in_ready_o low. A stalled receiver holds the result register
// and with it the input channel.
// ----------------------------------------------------------------------------
module static_linked_list_engine_top
  import sll_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic signed [31:0]  value_i,
  input  logic [SLOT_W-1:0]   position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [SLOT_W-1:0]   length_o
);

  state_e state_q, state_d;

  slot_t              init_q, init_d;
  slot_t              k_q, k_d;          // predecessor during a delete
  slot_t              sel_q, sel_d;      // slot taken or victim
  slot_t              walk_q, walk_d;
  slot_t              tail_q, tail_d;
  slot_t              count_q, count_d;
  logic [DATA_W-1:0]  value_q, value_d;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  slot_t              slot_q, slot_d;
  slot_t              length_q, length_d;

  logic  lk_we, lk_re, dt_we;
  slot_t lk_waddr, lk_wdata, lk_raddr, lk_rdata;

  logic in_fire, out_fire, bad_pos;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign bad_pos     = (position_i == '0) || (position_i > count_q);

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign length_o    = length_q;

  sll_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  // data words are stored only, never read back
  sll_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (sel_q),
    .wdata_i (value_q),
    .re_i    (1'b0),
    .raddr_i (sel_q),
    .rdata_o ()
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (init_q == slot_t'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (op_e'(kind_i) == OP_APPEND) begin
            state_d = S_A_HEAD;
          end else if (!bad_pos) begin
            state_d = S_D_WALK;
          end
        end
      end
      S_A_HEAD: begin
        state_d = (lk_rdata == '0) ? S_IDLE : S_A_NEXT;
      end
      S_A_NEXT:  state_d = S_A_CLR;
      S_A_CLR:   state_d = S_A_LINK;
      S_A_LINK:  state_d = S_IDLE;
      S_D_WALK: begin
        if (walk_q == '0) begin
          state_d = (lk_rdata == '0) ? S_IDLE : S_D_VNEXT;
        end
      end
      S_D_VNEXT: state_d = S_D_FREE;
      S_D_FREE:  state_d = S_D_PUSH;
      S_D_PUSH:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // memory accesses and datapath
  always_comb begin
    init_d      = init_q;
    k_d         = k_q;
    sel_d       = sel_q;
    walk_d      = walk_q;
    tail_d      = tail_q;
    count_d     = count_q;
    value_d     = value_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    length_d    = length_q;
    lk_we       = 1'b0;
    lk_waddr    = '0;
    lk_wdata    = '0;
    lk_re       = 1'b0;
    lk_raddr    = '0;
    dt_we       = 1'b0;

    case (state_q)
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = init_q;
        lk_wdata = link_reset_value(init_q);
        init_d   = init_q + slot_t'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          value_d = value_i;
          if (op_e'(kind_i) == OP_APPEND) begin
            lk_re    = 1'b1;
            lk_raddr = slot_t'(FREE_HEAD);
          end else if (bad_pos) begin
            out_valid_d = 1'b1;
            status_d    = ST_BAD_POS;
            slot_d      = '0;
            length_d    = count_q;
          end else begin
            k_d      = slot_t'(HEAD_SLOT);
            walk_d   = position_i - slot_t'(1);
            lk_re    = 1'b1;
            lk_raddr = slot_t'(HEAD_SLOT);
          end
        end
      end
      S_A_HEAD: begin
        if (lk_rdata == '0) begin
          out_valid_d = 1'b1;
          status_d    = ST_NO_FREE;
          slot_d      = '0;
          length_d    = count_q;
        end else begin
          sel_d    = lk_rdata;
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
        end
      end
      S_A_NEXT: begin
        // free head moves on to the next free slot
        lk_we    = 1'b1;
        lk_waddr = slot_t'(FREE_HEAD);
        lk_wdata = lk_rdata;
        dt_we    = 1'b1;
      end
      S_A_CLR: begin
        lk_we    = 1'b1;
        lk_waddr = sel_q;
        lk_wdata = '0;
      end
      S_A_LINK: begin
        lk_we       = 1'b1;
        lk_waddr    = tail_q;
        lk_wdata    = sel_q;
        tail_d      = sel_q;
        count_d     = count_q + slot_t'(1);
        out_valid_d = 1'b1;
        status_d    = ST_DONE;
        slot_d      = sel_q;
        length_d    = count_q + slot_t'(1);
      end
      S_D_WALK: begin
        if (walk_q != '0) begin
          k_d      = lk_rdata;
          walk_d   = walk_q - slot_t'(1);
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
        end else if (lk_rdata == '0) begin
          out_valid_d = 1'b1;
          status_d    = ST_BAD_POS;
          slot_d      = '0;
          length_d    = count_q;
        end else begin
          sel_d    = lk_rdata;
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
        end
      end
      S_D_VNEXT: begin
        // unlink victim, fetch free head in the same cycle
        lk_we    = 1'b1;
        lk_waddr = k_q;
        lk_wdata = lk_rdata;
        if (tail_q == sel_q) begin
          tail_d = k_q;
        end
        lk_re    = 1'b1;
        lk_raddr = slot_t'(FREE_HEAD);
      end
      S_D_FREE: begin
        lk_we    = 1'b1;
        lk_waddr = sel_q;
        lk_wdata = lk_rdata;
      end
      S_D_PUSH: begin
        lk_we       = 1'b1;
        lk_waddr    = slot_t'(FREE_HEAD);
        lk_wdata    = sel_q;
        count_d     = count_q - slot_t'(1);
        out_valid_d = 1'b1;
        status_d    = ST_DONE;
        slot_d      = sel_q;
        length_d    = count_q - slot_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      tail_q      <= slot_t'(HEAD_SLOT);
      count_q     <= '0;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      walk_q      <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    sel_q    <= sel_d;
    value_q  <= value_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    length_q <= length_d;
  end

endmodule

[hw/rtl/sll_ram.sv]
// ----------------------------------------------------------------------------
// sll_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
